@@ src/vag_pkg.sv @@
package vag_pkg;

    // default configuration
    localparam int COUNT_BITS_DEF  = 21;
    localparam int BLOCK_BYTES_DEF = 16;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 16;
    localparam int OUT_CNT_W   = 21;
    localparam int LEN_W       = 22;
    localparam int STATE_W     = 40;
    localparam int COEF_W      = 8;
    localparam int OUT_TDATA_W = 88;

    // block layout
    localparam int POS_SHIFT_FILTER = 0;
    localparam int POS_FLAGS        = 1;

    // flag byte bits
    localparam int FLAG_LOOP_END   = 0;
    localparam int FLAG_REPEAT     = 1;
    localparam int FLAG_LOOP_START = 2;

    localparam int LOOP_OFFSET = 26;

    // predictor fixed point
    localparam int PRED_FRAC   = 6;
    localparam int OUT_FRAC    = 10;
    localparam int NIBBLE_BASE = 22;

    // command queue depth
    localparam int Q_DEPTH = 2;

    // filter indices
    localparam logic [3:0] FILT_1 = 4'd1;
    localparam logic [3:0] FILT_2 = 4'd2;
    localparam logic [3:0] FILT_3 = 4'd3;
    localparam logic [3:0] FILT_4 = 4'd4;

    typedef struct packed {
        logic [BYTE_W-1:0]    data_byte;
        logic [BYTE_W-1:0]    shift_filter;
        logic                 clear_pred;
        logic [OUT_CNT_W-1:0] count_lo;
        logic [OUT_CNT_W-1:0] count_hi;
        logic                 loop_found;
        logic [OUT_CNT_W-1:0] loop_start;
        logic [LEN_W-1:0]     loop_length;
        logic                 stopped;
    } cmd_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] sample_count;
        logic                 loop_found;
        logic [OUT_CNT_W-1:0] loop_start;
        logic [LEN_W-1:0]     loop_length;
        logic                 stopped;
        logic                 last;
    } res_meta_t;

    // coefficients in 1/64 units, unknown filters act as filter 0
    function automatic logic signed [COEF_W-1:0] coef0(input logic [3:0] filt);
        logic signed [COEF_W-1:0] k;
        case (filt)
            FILT_1:  k = 8'sd60;
            FILT_2:  k = 8'sd115;
            FILT_3:  k = 8'sd98;
            FILT_4:  k = 8'sd122;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef1(input logic [3:0] filt);
        logic signed [COEF_W-1:0] k;
        case (filt)
            FILT_2:  k = -8'sd52;
            FILT_3:  k = -8'sd55;
            FILT_4:  k = -8'sd60;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage

@@ src/vag_front.sv @@
module vag_front #(
    parameter int COUNT_BITS  = vag_pkg::COUNT_BITS_DEF,
    parameter int BLOCK_BYTES = vag_pkg::BLOCK_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [vag_pkg::BYTE_W-1:0] data_byte,
    input  logic                       end_of_sound,
    input  logic                       stop_at_loop_end,
    output logic                       push,
    output vag_pkg::cmd_t              cmd
);
    import vag_pkg::*;

    localparam int POS_W = $clog2(BLOCK_BYTES);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [BYTE_W-1:0]       sf_reg, sf_next;
    logic [BYTE_W-1:0]       flag_reg, flag_next;
    logic [COUNT_BITS-1:0]   done_reg, done_next;
    logic [COUNT_BITS-1:0]   lsm_reg, lsm_next;
    logic [COUNT_BITS-1:0]   target_reg, target_next;
    logic                    armed_reg, armed_next;
    logic                    found_reg, found_next;
    logic [COUNT_BITS-1:0]   start_reg, start_next;
    logic signed [COUNT_BITS:0] len_reg, len_next;
    logic                    halted_reg, halted_next;
    logic                    pend_reg, pend_next;

    logic                    accept;
    logic [COUNT_BITS:0]     sum_a, sum_b, sum_m;
    logic [COUNT_BITS-1:0]   cnt_a, cnt_b, mark;
    logic                    stop_hit;
    logic                    rep_hit;
    logic [COUNT_BITS-1:0]   lsm_eff, rep_start;
    logic signed [COUNT_BITS:0] rep_len;

    assign accept = in_valid && in_ready;

    // saturating counts for the two samples and the loop mark
    assign sum_a = {1'b0, done_reg} + (COUNT_BITS+1)'(1);
    assign cnt_a = sum_a[COUNT_BITS] ? CNT_MAX : sum_a[COUNT_BITS-1:0];
    assign sum_b = {1'b0, cnt_a} + (COUNT_BITS+1)'(1);
    assign cnt_b = sum_b[COUNT_BITS] ? CNT_MAX : sum_b[COUNT_BITS-1:0];
    assign sum_m = {1'b0, cnt_b} + (COUNT_BITS+1)'(LOOP_OFFSET);
    assign mark  = sum_m[COUNT_BITS] ? CNT_MAX : sum_m[COUNT_BITS-1:0];

    assign stop_hit = stop_at_loop_end && armed_reg && (cnt_b == target_reg);

    // loop report as it stands once this byte is handled, before any end of sound
    assign rep_hit   = !stop_hit && !armed_reg &&
                       flag_reg[FLAG_LOOP_END] && flag_reg[FLAG_REPEAT];
    assign lsm_eff   = flag_reg[FLAG_LOOP_START] ? mark : lsm_reg;
    assign rep_start = rep_hit ? lsm_eff : start_reg;
    assign rep_len   = rep_hit ? (signed'({1'b0, mark}) - signed'({1'b0, lsm_eff})) : len_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        sf_next     = sf_reg;
        flag_next   = flag_reg;
        done_next   = done_reg;
        lsm_next    = lsm_reg;
        target_next = target_reg;
        armed_next  = armed_reg;
        found_next  = found_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        halted_next = halted_reg;
        pend_next   = pend_reg;
        push        = 1'b0;
        if (accept)
        begin
            if (!halted_reg)
            begin
                pos_next = (pos_reg == POS_W'(BLOCK_BYTES-1)) ? '0 : pos_reg + POS_W'(1);
                if (pos_reg == POS_W'(POS_SHIFT_FILTER))
                begin
                    sf_next = data_byte;
                end
                else if (pos_reg == POS_W'(POS_FLAGS))
                begin
                    flag_next = data_byte;
                end
                else
                begin
                    push      = 1'b1;
                    done_next = cnt_b;
                    pend_next = 1'b0;
                    if (stop_hit)
                    begin
                        halted_next = 1'b1;
                    end
                    else if (!armed_reg)
                    begin
                        if (flag_reg[FLAG_LOOP_START])
                        begin
                            lsm_next = mark;
                        end
                        if (flag_reg[FLAG_LOOP_END])
                        begin
                            if (flag_reg[FLAG_REPEAT])
                            begin
                                found_next = 1'b1;
                                start_next = lsm_next;
                                len_next   = signed'({1'b0, mark}) - signed'({1'b0, lsm_next});
                            end
                            if (stop_at_loop_end)
                            begin
                                target_next = mark;
                                armed_next  = 1'b1;
                            end
                        end
                    end
                end
            end
            if (end_of_sound)
            begin
                pos_next    = '0;
                sf_next     = '0;
                flag_next   = '0;
                done_next   = '0;
                lsm_next    = '0;
                target_next = '0;
                armed_next  = 1'b0;
                found_next  = 1'b0;
                start_next  = '0;
                len_next    = '0;
                halted_next = 1'b0;
                pend_next   = 1'b1;
            end
        end
    end

    // request to the back end carries the loop state after the whole byte
    always_comb
    begin
        cmd.data_byte    = data_byte;
        cmd.shift_filter = sf_reg;
        cmd.clear_pred   = pend_reg;
        cmd.count_lo     = OUT_CNT_W'(cnt_a);
        cmd.count_hi     = OUT_CNT_W'(cnt_b);
        cmd.loop_found   = found_reg || rep_hit;
        cmd.loop_start   = OUT_CNT_W'(rep_start);
        cmd.loop_length  = LEN_W'(rep_len);
        cmd.stopped      = stop_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sf_reg     <= '0;
            flag_reg   <= '0;
            done_reg   <= '0;
            lsm_reg    <= '0;
            target_reg <= '0;
            armed_reg  <= 1'b0;
            found_reg  <= 1'b0;
            start_reg  <= '0;
            len_reg    <= '0;
            halted_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sf_reg     <= sf_next;
            flag_reg   <= flag_next;
            done_reg   <= done_next;
            lsm_reg    <= lsm_next;
            target_reg <= target_next;
            armed_reg  <= armed_next;
            found_reg  <= found_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            halted_reg <= halted_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

@@ src/vag_queue.sv @@
module vag_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vag_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output vag_pkg::cmd_t head_cmd
);
    import vag_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/vag_back.sv @@
module vag_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  vag_pkg::cmd_t                       head_cmd,
    output logic                                pop,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [vag_pkg::SAMPLE_W-1:0] res_sample,
    output vag_pkg::res_meta_t                  res_meta
);
    import vag_pkg::*;

    localparam int PROD_W = STATE_W + COEF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int PRED_W = SUM_W - PRED_FRAC;
    localparam int ACC_W  = PRED_W + 2;
    localparam int RND_W  = STATE_W + 1;
    localparam int Q_W    = RND_W - OUT_FRAC;

    localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

    logic                        phase_reg, phase_next;
    logic signed [STATE_W-1:0]   prev_reg, prev_next;
    logic signed [STATE_W-1:0]   older_reg, older_next;
    logic                        sv_reg, sv_next;
    logic signed [STATE_W-1:0]   s_reg;
    res_meta_t                   smeta_reg;
    logic                        ov_reg, ov_next;
    logic signed [SAMPLE_W-1:0]  out_reg;
    res_meta_t                   ometa_reg;

    logic                        out_load, a_ready, issue;
    logic signed [STATE_W-1:0]   prev_eff, older_eff;
    logic [3:0]                  filt, shift, nib;
    logic signed [PROD_W-1:0]    p0, p1;
    logic signed [SUM_W-1:0]     psum, psum_r;
    logic signed [PRED_W-1:0]    pred;
    logic signed [ACC_W-1:0]     nterm, acc;
    logic signed [STATE_W-1:0]   s_new;
    logic [4:0]                  nib_shift;
    logic signed [RND_W-1:0]     y;
    logic signed [Q_W-1:0]       q;
    logic signed [SAMPLE_W-1:0]  q_sat;
    res_meta_t                   meta_new;

    assign out_load = sv_reg && (!ov_reg || res_ready);
    assign a_ready  = !sv_reg || out_load;
    assign issue    = head_valid && a_ready;
    assign pop      = issue && phase_reg;

    // predictor: one sample per cycle unless the output side stalls, low nibble first
    assign prev_eff  = (head_cmd.clear_pred && !phase_reg) ? '0 : prev_reg;
    assign older_eff = (head_cmd.clear_pred && !phase_reg) ? '0 : older_reg;
    assign filt      = head_cmd.shift_filter[7:4];
    assign shift     = head_cmd.shift_filter[3:0];
    assign nib       = phase_reg ? head_cmd.data_byte[7:4] : head_cmd.data_byte[3:0];

    assign p0   = prev_eff * coef0(filt);
    assign p1   = older_eff * coef1(filt);
    assign psum = SUM_W'(p0) + SUM_W'(p1);
    // round half away from zero on the dropped fraction
    assign psum_r = psum + (psum[SUM_W-1] ? SUM_W'(31) : SUM_W'(32));
    assign pred   = psum_r[SUM_W-1:PRED_FRAC];

    assign nib_shift = 5'(NIBBLE_BASE) - {1'b0, shift};
    assign nterm     = ACC_W'(signed'(nib)) <<< nib_shift;
    assign acc       = ACC_W'(pred) + nterm;

    always_comb
    begin
        if (acc[ACC_W-1:STATE_W-1] == '0 || acc[ACC_W-1:STATE_W-1] == '1)
        begin
            s_new = acc[STATE_W-1:0];
        end
        else
        begin
            s_new = acc[ACC_W-1] ? ST_MIN : ST_MAX;
        end
    end

    always_comb
    begin
        meta_new.sample_count = phase_reg ? head_cmd.count_hi : head_cmd.count_lo;
        meta_new.loop_found   = head_cmd.loop_found;
        meta_new.loop_start   = head_cmd.loop_start;
        meta_new.loop_length  = head_cmd.loop_length;
        meta_new.stopped      = phase_reg && head_cmd.stopped;
        meta_new.last         = phase_reg;
    end

    // output rounding and clipping to 16 bits
    assign y = RND_W'(s_reg) + (s_reg[STATE_W-1] ? RND_W'(511) : RND_W'(512));
    assign q = y[RND_W-1:OUT_FRAC];

    always_comb
    begin
        if (q[Q_W-1:SAMPLE_W-1] == '0 || q[Q_W-1:SAMPLE_W-1] == '1)
        begin
            q_sat = q[SAMPLE_W-1:0];
        end
        else
        begin
            q_sat = q[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        older_next = older_reg;
        sv_next    = sv_reg;
        ov_next    = ov_reg;
        if (issue)
        begin
            phase_next = !phase_reg;
            prev_next  = s_new;
            older_next = prev_eff;
            sv_next    = 1'b1;
        end
        else if (out_load)
        begin
            sv_next = 1'b0;
        end
        if (out_load)
        begin
            ov_next = 1'b1;
        end
        else if (res_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s_reg     <= s_new;
            smeta_reg <= meta_new;
        end
        if (out_load)
        begin
            out_reg   <= q_sat;
            ometa_reg <= smeta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            prev_reg  <= '0;
            older_reg <= '0;
            sv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            older_reg <= older_next;
            sv_reg    <= sv_next;
            ov_reg    <= ov_next;
        end
    end

    assign res_valid  = ov_reg;
    assign res_sample = out_reg;
    assign res_meta   = ometa_reg;

endmodule

@@ src/vag_adpcm_stream_decoder.sv @@
// path: a data byte goes through the request queue, the predictor sample register
//   and the output register, low-nibble sample first; header bytes give no result
// throughput: one byte a cycle in while the request queue is not full; the
//   predictor sets the overall rate, one sample a cycle unless the output stalls;
//   a two-entry request queue overlaps header bytes and output stalls with decoding
// reset: rst_n clears all control state, the predictor and stop_at_loop_end at once
module vag_adpcm_stream_decoder #(
    parameter int COUNT_BITS  = vag_pkg::COUNT_BITS_DEF,
    parameter int BLOCK_BYTES = vag_pkg::BLOCK_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: stop_at_loop_end
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    // byte stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vag_pkg::BYTE_W-1:0]      s_tdata,  // [7:0] data_byte
    input  logic                            s_tlast,  // end_of_sound
    // sample stream out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] pcm_sample, [36:16] sample_count, [37] loop_found,
    // [58:38] loop_start, [80:59] loop_length, [81] stopped, [87:82] zero
    output logic [vag_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast   // last
);
    import vag_pkg::*;

    // stop mode register; the user must write it only while the decoder is idle, the block does not enforce it
    logic stop_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_cfg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            stop_cfg_reg <= cfg_wdata;
        end
    end

    // front end: block position, header capture, sample counting, loop and stop
    // bookkeeping; every data byte up to a stop at loop end becomes one request for the back end
    logic q_full, f_push;
    cmd_t f_cmd;

    assign s_tready = !q_full;

    vag_front #(
        .COUNT_BITS  (COUNT_BITS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .data_byte        (s_tdata),
        .end_of_sound     (s_tlast),
        .stop_at_loop_end (stop_cfg_reg),
        .push             (f_push),
        .cmd              (f_cmd)
    );

    // short request queue so the front keeps taking bytes while the back works
    logic q_pop, q_valid;
    cmd_t q_cmd;

    vag_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_cmd   (f_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    // back end: two-tap predictor, one nibble a cycle unless the output stalls, then
    // rounding into the output register
    logic signed [SAMPLE_W-1:0] b_sample;
    res_meta_t                  b_meta;

    vag_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_cmd   (q_cmd),
        .pop        (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_sample (b_sample),
        .res_meta   (b_meta)
    );

    // pack the result fields, first field lowest
    assign m_tdata = {6'b0,
                      b_meta.stopped,
                      b_meta.loop_length,
                      b_meta.loop_start,
                      b_meta.loop_found,
                      b_meta.sample_count,
                      b_sample};
    assign m_tlast = b_meta.last;

endmodule
